@@ rtl/stbs_pkg.sv @@
// Shared constants and types for the sorted table binary search block.
`timescale 1ns / 1ps
package stbs_pkg;

  localparam int TABLE_DEPTH = 16;
  localparam int IDX_W       = 4;
  localparam int VAL_W       = 32;
  localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam logic FUNC_WRITE  = 1'b0;
  localparam logic FUNC_SEARCH = 1'b1;

  typedef struct packed {
    logic                    func;
    logic [IDX_W-1:0]        entry_index;
    logic signed [VAL_W-1:0] item_value;
  } item_t;

  typedef struct packed {
    logic full;
    logic empty;
  } queue_status_t;

endpackage

@@ rtl/stbs_front.sv @@
// Front part: accepts input transfers, drops out-of-range writes, feeds the queue.
`timescale 1ns / 1ps
module stbs_front (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic                            func_i,
  input  logic [stbs_pkg::IDX_W-1:0]      entry_index_i,
  input  logic signed [stbs_pkg::VAL_W-1:0] item_value_i,
  input  stbs_pkg::queue_status_t         q_status_i,
  output logic                            push_o,
  output stbs_pkg::item_t                 push_item_o
);

  logic            hold_valid_q, hold_valid_d;
  stbs_pkg::item_t hold_q;
  logic            accept;
  logic            keep;

  assign in_stall_o  = hold_valid_q && q_status_i.full;
  assign accept      = in_valid_i && !in_stall_o;
  assign push_o      = hold_valid_q && !q_status_i.full;
  assign push_item_o = hold_q;

  // drop writes beyond the table
  assign keep = (func_i == stbs_pkg::FUNC_SEARCH) ||
                ({1'b0, entry_index_i} < (stbs_pkg::IDX_W + 1)'(stbs_pkg::TABLE_DEPTH));

  always_comb begin
    hold_valid_d = hold_valid_q;
    if (push_o) begin
      hold_valid_d = 1'b0;
    end
    if (accept) begin
      hold_valid_d = keep;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_valid_q <= 1'b0;
    end else begin
      hold_valid_q <= hold_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      hold_q.func        <= func_i;
      hold_q.entry_index <= entry_index_i;
      hold_q.item_value  <= item_value_i;
    end
  end

endmodule

@@ rtl/stbs_queue.sv @@
// Short in-order queue between the front and back parts.
`timescale 1ns / 1ps
module stbs_queue (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    push_i,
  input  stbs_pkg::item_t         push_item_i,
  input  logic                    pop_i,
  output stbs_pkg::item_t         head_o,
  output stbs_pkg::queue_status_t status_o
);

  stbs_pkg::item_t                 mem_q [stbs_pkg::QUEUE_DEPTH];
  logic [stbs_pkg::QPTR_W-1:0]     wr_ptr_q, rd_ptr_q;
  logic [stbs_pkg::QCNT_W-1:0]     count_q;

  function automatic logic [stbs_pkg::QPTR_W-1:0] next_ptr(
    input logic [stbs_pkg::QPTR_W-1:0] p
  );
    if (p == stbs_pkg::QPTR_W'(stbs_pkg::QUEUE_DEPTH - 1)) begin
      return '0;
    end
    return p + 1'b1;
  endfunction

  assign status_o.full  = (count_q == stbs_pkg::QCNT_W'(stbs_pkg::QUEUE_DEPTH));
  assign status_o.empty = (count_q == '0);
  assign head_o         = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= next_ptr(wr_ptr_q);
      end
      if (pop_i) begin
        rd_ptr_q <= next_ptr(rd_ptr_q);
      end
      unique case ({push_i, pop_i})
        2'b10:   count_q <= count_q + 1'b1;
        2'b01:   count_q <= count_q - 1'b1;
        default: count_q <= count_q;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_item_i;
    end
  end

endmodule

@@ rtl/stbs_back.sv @@
// Back part: table storage, probe sequencer and result register.
`timescale 1ns / 1ps
module stbs_back (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [stbs_pkg::CNT_W-1:0]  cfg_wdata_i,
  input  stbs_pkg::item_t             head_i,
  input  stbs_pkg::queue_status_t     q_status_i,
  output logic                        pop_o,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic                        found_o,
  output logic [stbs_pkg::IDX_W-1:0]  position_o
);

  typedef enum logic {
    ST_IDLE,
    ST_SEARCH
  } state_e;

  localparam int SUM_W = stbs_pkg::CNT_W + 1;

  state_e                             state_q;
  logic [stbs_pkg::CNT_W-1:0]         entry_count_q;
  logic [stbs_pkg::CNT_W-1:0]         eff_count;
  logic [stbs_pkg::CNT_W-1:0]         low_q, high_q;
  logic signed [stbs_pkg::VAL_W-1:0]  target_q;
  logic signed [stbs_pkg::VAL_W-1:0]  mem_q [stbs_pkg::TABLE_DEPTH];
  logic                               out_valid_q, found_q;
  logic [stbs_pkg::IDX_W-1:0]         position_q;
  logic                               out_free;
  logic                               start_search;
  logic                               do_write;
  logic [SUM_W-1:0]                   mid_sum;
  logic [stbs_pkg::CNT_W-1:0]         mid;
  logic signed [stbs_pkg::VAL_W-1:0]  probe;
  logic                               bounds_crossed;

  assign eff_count = (entry_count_q > stbs_pkg::CNT_W'(stbs_pkg::TABLE_DEPTH)) ?
                     stbs_pkg::CNT_W'(stbs_pkg::TABLE_DEPTH) : entry_count_q;

  assign out_free     = !out_valid_q || !out_stall_i;
  assign do_write     = (state_q == ST_IDLE) && !q_status_i.empty &&
                        (head_i.func == stbs_pkg::FUNC_WRITE);
  assign start_search = (state_q == ST_IDLE) && !q_status_i.empty &&
                        (head_i.func == stbs_pkg::FUNC_SEARCH) && out_free;
  assign pop_o        = do_write || start_search;

  // high_q holds one past the upper bound
  assign bounds_crossed = (low_q >= high_q);
  assign mid_sum        = SUM_W'(low_q) + SUM_W'(high_q) - SUM_W'(1);
  assign mid            = mid_sum[SUM_W-1:1];
  assign probe          = mem_q[mid[stbs_pkg::IDX_W-1:0]];

  assign out_valid_o = out_valid_q;
  assign found_o     = found_q;
  assign position_o  = position_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_IDLE;
      entry_count_q <= '0;
      out_valid_q   <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        entry_count_q <= cfg_wdata_i;
      end
      if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (start_search) begin
            state_q <= ST_SEARCH;
          end
        end
        ST_SEARCH: begin
          if (bounds_crossed || (probe == target_q)) begin
            out_valid_q <= 1'b1;
            state_q     <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_write) begin
      mem_q[head_i.entry_index] <= head_i.item_value;
    end
    if (start_search) begin
      low_q    <= '0;
      high_q   <= eff_count;
      target_q <= head_i.item_value;
    end else if (state_q == ST_SEARCH) begin
      if (bounds_crossed) begin
        found_q    <= 1'b0;
        position_q <= '0;
      end else if (probe == target_q) begin
        found_q    <= 1'b1;
        position_q <= mid[stbs_pkg::IDX_W-1:0];
      end else if (probe > target_q) begin
        high_q <= mid;
      end else begin
        low_q <= mid + 1'b1;
      end
    end
  end

  a_bounds_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SEARCH) |-> (high_q <= eff_count) && (low_q <= high_q + 1'b1))
    else $error("search bounds left the table");

  a_search_owns_output: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SEARCH) |-> !out_valid_q)
    else $error("search running while a result is pending");

  a_found_in_table: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SEARCH) && !bounds_crossed && (probe == target_q) |=>
      out_valid_q && found_q)
    else $error("match not reported");

  a_no_pop_while_search: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SEARCH) |-> !pop_o)
    else $error("queue popped during a search");

endmodule

@@ rtl/sorted_table_binary_search.sv @@
// Top level of the sorted table binary search block.
`timescale 1ns / 1ps
// Holds a 16-entry table of signed 32-bit values written by write items
// (func 0) and answered by search items (func 1), which return found and
// position. A write updates the table in the back part while it is idle.
// A search waits for the result register to be free, loads its bounds,
// then probes the table once per step, halving the bounds, until it finds
// a match or sees the bounds cross. The front part and a two-entry queue
// keep taking items while a search runs, until the queue and the front's
// holding register are full. The user must write entry_count through
// cfg_we_i / cfg_wdata_i only while the block is idle; the block does not
// enforce this. Values above 16 act as 16. Entries must be written before
// a search probes them.
module sorted_table_binary_search (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [stbs_pkg::CNT_W-1:0]        cfg_wdata_i,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic                              func_i,
  input  logic [stbs_pkg::IDX_W-1:0]        entry_index_i,
  input  logic signed [stbs_pkg::VAL_W-1:0] item_value_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic                              found_o,
  output logic [stbs_pkg::IDX_W-1:0]        position_o
);

  stbs_pkg::queue_status_t q_status;
  stbs_pkg::item_t         push_item, head_item;
  logic                    push, pop;

  stbs_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .func_i        (func_i),
    .entry_index_i (entry_index_i),
    .item_value_i  (item_value_i),
    .q_status_i    (q_status),
    .push_o        (push),
    .push_item_o   (push_item)
  );

  stbs_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_item_i (push_item),
    .pop_i       (pop),
    .head_o      (head_item),
    .status_o    (q_status)
  );

  stbs_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .head_i      (head_item),
    .q_status_i  (q_status),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .found_o     (found_o),
    .position_o  (position_o)
  );

endmodule
